// ===== hdl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// SD SPI host sequencer package
// Phase encoding, command kinds, request codes and command frame bytes.
// ----------------------------------------------------------------------------
package sdspi_pkg;

	// Request codes carried with each input transfer.
	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_INIT = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_POLL_LIMIT   = 2'd0;
	localparam logic [1:0] CFG_WAKE_DUMMIES = 2'd1;

	localparam logic [15:0] POLL_LIMIT_RESET   = 16'd8000;
	localparam logic [15:0] WAKE_DUMMIES_RESET = 16'd1000;

	localparam int unsigned BLOCK_BYTES_DEFAULT = 512;

	// Status codes.
	localparam logic [2:0] ST_BUSY = 3'd0;

	localparam logic [7:0] IDLE_BYTE   = 8'hFF;
	localparam logic [7:0] START_TOKEN = 8'hFE;
	localparam logic [7:0] R1_IDLE     = 8'h01;
	localparam logic [11:0] R7_ECHO    = 12'h1AA;

	typedef enum logic [2:0] {
		K_CMD0   = 3'd0,
		K_CMD8   = 3'd1,
		K_CMD55  = 3'd2,
		K_ACMD41 = 3'd3,
		K_CMD17  = 3'd4
	} kind_t;

	// Terminal phases double as status codes (low three bits).
	typedef enum logic [4:0] {
		PH_IDLE        = 5'd0,
		PH_DONE        = 5'd1,
		PH_E_NORESET   = 5'd2,
		PH_E_OLD       = 5'd3,
		PH_E_PATTERN   = 5'd4,
		PH_E_REJECT    = 5'd5,
		PH_WAKE        = 5'd6,
		PH_SEND_CMD0   = 5'd7,
		PH_SEND_CMD8   = 5'd8,
		PH_SEND_CMD55  = 5'd9,
		PH_SEND_ACMD41 = 5'd10,
		PH_SEND_CMD17  = 5'd11,
		PH_POLL_CMD0   = 5'd12,
		PH_POLL_CMD8   = 5'd13,
		PH_POLL_CMD55  = 5'd14,
		PH_POLL_ACMD41 = 5'd15,
		PH_POLL_CMD17  = 5'd16,
		PH_W_ONE       = 5'd17,
		PH_W_CMD8      = 5'd18,
		PH_R7          = 5'd19,
		PH_W_R7END     = 5'd20,
		PH_W_CMD55     = 5'd21,
		PH_W_ACMD41    = 5'd22,
		PH_W_FINAL     = 5'd23,
		PH_W_CMD17     = 5'd24,
		PH_TOKEN       = 5'd25,
		PH_DATA        = 5'd26,
		PH_CRC         = 5'd27
	} phase_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       chip_select_low;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       last_data;
		logic [2:0] status;
	} result_t;

	// Byte at position pos of the command frame of kind k.
	function automatic logic [7:0] frame_byte(kind_t k, logic [2:0] pos, logic [31:0] addr);
		logic [7:0] b;
		b = IDLE_BYTE;
		unique case (k)
			K_CMD0: begin
				unique case (pos)
					3'd0: b = 8'h40;
					3'd5: b = 8'h95;
					3'd6, 3'd7: b = IDLE_BYTE;
					default: b = 8'h00;
				endcase
			end
			K_CMD8: begin
				unique case (pos)
					3'd0: b = 8'h48;
					3'd3: b = 8'h01;
					3'd4: b = 8'hAA;
					3'd5: b = 8'h87;
					3'd6, 3'd7: b = IDLE_BYTE;
					default: b = 8'h00;
				endcase
			end
			K_CMD55: begin
				unique case (pos)
					3'd0: b = 8'h77;
					3'd5, 3'd6, 3'd7: b = IDLE_BYTE;
					default: b = 8'h00;
				endcase
			end
			K_ACMD41: begin
				unique case (pos)
					3'd0: b = 8'h69;
					3'd1: b = 8'h40;
					3'd5, 3'd6, 3'd7: b = IDLE_BYTE;
					default: b = 8'h00;
				endcase
			end
			default: begin
				unique case (pos)
					3'd0: b = 8'h51;
					3'd1: b = addr[31:24];
					3'd2: b = addr[23:16];
					3'd3: b = addr[15:8];
					3'd4: b = addr[7:0];
					default: b = IDLE_BYTE;
				endcase
			end
		endcase
		return b;
	endfunction

	// Phase that follows a command reply r.
	function automatic phase_t reply_phase(kind_t k, logic [7:0] r);
		phase_t p;
		p = PH_E_REJECT;
		unique case (k)
			K_CMD0: begin
				if (r == IDLE_BYTE) p = PH_E_NORESET;
				else if (r == R1_IDLE) p = PH_W_CMD8;
				else p = PH_W_ONE;
			end
			K_CMD8:   p = r[2] ? PH_E_OLD : PH_R7;
			K_CMD55:  p = PH_W_ACMD41;
			K_ACMD41: p = (r == 8'h00) ? PH_W_FINAL : PH_W_CMD55;
			default:  p = (r == 8'h00) ? PH_TOKEN : PH_E_REJECT;
		endcase
		return p;
	endfunction

endpackage

// ===== hdl/sd_spi_host_sequencer.sv =====
// ----------------------------------------------------------------------------
// SD SPI host sequencer
// Card initialization and single-block read, one SPI byte exchange per transfer.
// ----------------------------------------------------------------------------
// An input transfer's result is registered in the result register, or in the skid
// register while the output stalls. One input transfer per cycle while the skid
// register is empty; the whole next-state decision is one pass of logic from the
// state registers to the result register. This two-entry output keeps the input
// open for one more transfer while a result waits. Reset clears the phase to idle,
// the counters to zero and the configuration to 8000 poll bytes, 1000 dummies.
module sd_spi_host_sequencer #(
	parameter int unsigned BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // blk_num[22:0], rx_byte[30:23], zero[31]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // tx_byte[7:0], chip_select_low[8], data_byte[16:9],
	                              // status[19:17], zero[23:20]
	output logic [1:0]  m_tuser,  // tx_valid[0], data_valid[1]
	output logic        m_tlast,  // last_data
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sdspi_pkg::*;

	localparam logic [15:0] BlockBytes16 = 16'(BLOCK_BYTES);
	localparam logic [31:0] BlockBytes32 = 32'(BLOCK_BYTES);

	// Configuration registers. Writes to indexes beyond the list are dropped.
	logic [15:0] poll_limit_q;
	logic [15:0] wake_dummies_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q   <= POLL_LIMIT_RESET;
			wake_dummies_q <= WAKE_DUMMIES_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_POLL_LIMIT) poll_limit_q <= cfg_data;
			if (cfg_index == CFG_WAKE_DUMMIES) wake_dummies_q <= cfg_data;
		end
	end

	// Sequencer state.
	phase_t      phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [2:0]  pos_q, pos_d;
	logic [31:0] addr_q, addr_d;
	logic [11:0] echo_q, echo_d;

	logic [1:0]  req;
	logic [22:0] blk_num;
	logic [7:0]  rx_byte;
	logic        accept;

	assign req      = s_tuser;
	assign blk_num  = s_tdata[22:0];
	assign rx_byte  = s_tdata[30:23];
	assign accept   = s_tvalid && s_tready;

	logic [15:0] count_inc;
	logic [2:0]  pos_inc;
	logic [11:0] echo_shift;
	kind_t       cur_kind;
	kind_t       poll_kind;
	logic        do_reply;
	kind_t       reply_kind;
	logic [7:0]  reply_byte;
	result_t     res;

	assign count_inc  = count_q + 16'd1;
	assign pos_inc    = pos_q + 3'd1;
	assign echo_shift = {echo_q[3:0], rx_byte};
	assign cur_kind   = kind_t'(3'(5'(phase_q) - 5'(PH_SEND_CMD0)));
	assign poll_kind  = kind_t'(3'(5'(phase_q) - 5'(PH_POLL_CMD0)));

	// Next state and result for the transfer on the input.
	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		pos_d      = pos_q;
		addr_d     = addr_q;
		echo_d     = echo_q;
		do_reply   = 1'b0;
		reply_kind = K_CMD0;
		reply_byte = IDLE_BYTE;
		res        = '0;

		unique case (req)
			REQ_INIT: begin
				// A restart is taken in any phase.
				count_d = '0;
				if (wake_dummies_q == 16'd0) begin
					phase_d = PH_SEND_CMD0;
					pos_d   = '0;
				end else begin
					phase_d = PH_WAKE;
				end
			end
			REQ_READ: begin
				if (phase_q == PH_DONE || phase_q == PH_E_REJECT) begin
					addr_d  = 32'(32'(blk_num) * BlockBytes32);
					phase_d = PH_W_CMD17;
				end
			end
			REQ_BYTE: begin
				priority if (phase_q >= PH_SEND_CMD0 && phase_q <= PH_SEND_CMD17) begin
					// Command frame going out; poll for the reply after six bytes.
					pos_d = pos_inc;
					if (pos_inc >= 3'd6) begin
						phase_d = phase_t'(5'(PH_POLL_CMD0) + 5'(cur_kind));
						count_d = '0;
						if (poll_limit_q == 16'd0) begin
							do_reply   = 1'b1;
							reply_kind = cur_kind;
						end
					end
				end else if (phase_q >= PH_POLL_CMD0 && phase_q <= PH_POLL_CMD17) begin
					reply_kind = poll_kind;
					if (rx_byte != IDLE_BYTE) begin
						do_reply   = 1'b1;
						reply_byte = rx_byte;
					end else begin
						// A timed-out reply is treated as an idle byte.
						count_d = count_inc;
						if (count_inc >= poll_limit_q) do_reply = 1'b1;
					end
				end else begin
					unique case (phase_q)
						PH_WAKE: begin
							count_d = count_inc;
							if (count_inc >= wake_dummies_q) begin
								phase_d = PH_SEND_CMD0;
								pos_d   = '0;
							end
						end
						PH_W_ONE: if (rx_byte == R1_IDLE) phase_d = PH_W_CMD8;
						PH_W_CMD8: begin
							if (rx_byte == IDLE_BYTE) begin
								phase_d = PH_SEND_CMD8;
								pos_d   = '0;
							end
						end
						PH_R7: begin
							// Collect the four R7 trailer bytes; the low 12 bits carry the echo.
							echo_d = echo_shift;
							pos_d  = pos_inc;
							if (pos_inc >= 3'd4)
								phase_d = (echo_shift == R7_ECHO) ? PH_W_R7END : PH_E_PATTERN;
						end
						PH_W_R7END: if (rx_byte == IDLE_BYTE) phase_d = PH_W_CMD55;
						PH_W_CMD55: begin
							if (rx_byte == IDLE_BYTE) begin
								phase_d = PH_SEND_CMD55;
								pos_d   = '0;
							end
						end
						PH_W_ACMD41: begin
							if (rx_byte == IDLE_BYTE) begin
								phase_d = PH_SEND_ACMD41;
								pos_d   = '0;
							end
						end
						PH_W_FINAL: if (rx_byte == IDLE_BYTE) phase_d = PH_DONE;
						PH_W_CMD17: begin
							if (rx_byte == IDLE_BYTE) begin
								phase_d = PH_SEND_CMD17;
								pos_d   = '0;
							end
						end
						PH_TOKEN: begin
							if (rx_byte == START_TOKEN) begin
								phase_d = PH_DATA;
								count_d = '0;
							end
						end
						PH_DATA: begin
							res.data_valid = 1'b1;
							res.data_byte  = rx_byte;
							count_d        = count_inc;
							if (count_inc >= BlockBytes16) begin
								res.last_data = 1'b1;
								phase_d       = PH_CRC;
								pos_d         = '0;
							end
						end
						PH_CRC: begin
							pos_d = pos_inc;
							if (pos_inc >= 3'd2) phase_d = PH_DONE;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase

		// Command reply handling shared by the frame end and the poll phases.
		if (do_reply) begin
			phase_d = reply_phase(reply_kind, reply_byte);
			if (reply_kind == K_CMD8 && !reply_byte[2]) begin
				pos_d  = '0;
				echo_d = '0;
			end
		end

		// Result fields follow from the new state.
		res.tx_valid        = (phase_d > PH_E_REJECT);
		res.chip_select_low = !(phase_d == PH_IDLE || phase_d == PH_WAKE);
		res.status          = ST_BUSY;
		if (res.tx_valid) begin
			if (phase_d >= PH_SEND_CMD0 && phase_d <= PH_SEND_CMD17)
				res.tx_byte = frame_byte(kind_t'(3'(5'(phase_d) - 5'(PH_SEND_CMD0))),
					pos_d, addr_d);
			else
				res.tx_byte = IDLE_BYTE;
		end else begin
			res.status = 3'(phase_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			pos_q   <= '0;
			addr_q  <= '0;
			echo_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			addr_q  <= addr_d;
			echo_q  <= echo_d;
		end
	end

	// Output register with a skid register behind it.
	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    out_free;

	assign s_tready = !skid_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.status, out_q.data_byte, out_q.chip_select_low,
		out_q.tx_byte};
	assign m_tuser  = {out_q.data_valid, out_q.tx_valid};
	assign m_tlast  = out_q.last_data;

	// The skid register only fills behind a stalled result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result with the output register empty");

	// An accepted init request always restarts at the wake dummies or at CMD0.
	a_init_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req == REQ_INIT) |=> (phase_q == PH_WAKE || phase_q == PH_SEND_CMD0))
		else $error("init request did not restart the sequence");

	// A final data byte is always a delivered data byte.
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser[1])
		else $error("last_data without data_valid");

	// An outcome status is only reported when no exchange is requested.
	a_status_idle_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[19:17] != ST_BUSY) |-> !m_tuser[0])
		else $error("outcome status reported with a pending exchange");

endmodule
